>>> design/alidf_pkg.sv
// ----------------------------------------------------------------------------
// alidf_pkg
// Shared types and codes for the array list insert/delete/filter block.
// ----------------------------------------------------------------------------
package alidf_pkg;

    typedef logic [1:0] t_mode;

    localparam t_mode MODE_INSERT = 2'd0;
    localparam t_mode MODE_DELETE = 2'd1;
    localparam t_mode MODE_FILTER = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_PUT,
        S_DONE
    } t_state;

endpackage

>>> design/alidf_ram.sv
// ----------------------------------------------------------------------------
// alidf_ram
// Single-clock list storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module alidf_ram #(
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [31:0]              o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [31:0]              i_wr_data
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/array_list_insert_delete_filter.sv
// ----------------------------------------------------------------------------
// array_list_insert_delete_filter
// Fixed-capacity ordered list of signed 32-bit words with insert, delete and
// remove-all-equal requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_ready): mode, 1-based position, value.
//   Response channel (o_out_valid / i_out_ready): status, removed value,
//   removed count and list length after the request.
//   One response per request, in request order.
// Operation:
//   insert  : shifts entries upward, then writes the new word; append only writes
//   delete  : shifts entries downward
//   filter  : one compaction pass over the list
//   rejected requests: answered without a pass over the list
//   The single list RAM moves one entry per cycle (read, then write back
//   in the next cycle), which sets the rate; only one request is in
//   flight at a time.
// Reset: the entry count returns to zero; list contents are not cleared
//   and are never read before written.
// Stall: the response sits in an output register. While it waits, the
//   block takes and works the next request, and holds that one's result
//   in the final state until the register is free.
// ----------------------------------------------------------------------------
module array_list_insert_delete_filter
    import alidf_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_mode,
    input  logic [7:0]         i_position,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_removed_value,
    output logic [7:0]         o_removed_count,
    output logic [7:0]         o_list_length
);

    localparam int AW = $clog2(CAPACITY);          // RAM address
    localparam int CW = $clog2(CAPACITY + 1);      // entry count
    localparam int XW = ((CW > 8) ? CW : 8) + 1;   // compare width

    // Control state
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_kept,  n_kept;
    logic [AW-1:0] r_idx,   n_idx;
    logic [AW-1:0] r_end,   n_end;
    logic          r_first, n_first;
    logic          r_pend_vld, n_pend_vld;
    logic          r_pend_take, n_pend_take;
    logic [AW-1:0] r_pend_addr, n_pend_addr;
    logic          r_out_vld, n_out_vld;

    // Request payload
    t_mode         r_mode,   n_mode;
    logic [31:0]   r_value,  n_value;
    t_status       r_status, n_status;
    logic [31:0]   r_taken;

    // Response payload
    t_status       r_o_status,   n_o_status;
    logic [31:0]   r_o_rm_value, n_o_rm_value;
    logic [7:0]    r_o_rm_count, n_o_rm_count;
    logic [7:0]    r_o_len,      n_o_len;

    // RAM ports
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_q;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          put_en;
    logic          filt_wr;
    logic          take_now;

    // Widened views for range checks
    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] new_cnt;
    logic [CW-1:0] hits;

    assign pos_x = XW'(i_position);
    assign cnt_x = XW'(r_count);
    assign hits  = r_count - r_kept;

    alidf_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_q),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // Write-back stage: data read in the previous cycle is written back in this one.
    // Insert writes one slot up, delete one slot down, filter writes kept
    // entries at the compaction pointer. Reads run ahead of writes, so a
    // write never targets a slot still to be read.
    always_comb begin
        take_now = r_pend_vld && r_pend_take;
        filt_wr  = r_pend_vld && (r_mode == MODE_FILTER) && (rd_q != r_value);
        wr_en    = put_en ||
                   (r_pend_vld && !r_pend_take &&
                    ((r_mode != MODE_FILTER) || (rd_q != r_value)));
        if (put_en) begin
            wr_addr = r_end;
            wr_data = r_value;
        end else if (r_mode == MODE_FILTER) begin
            wr_addr = r_kept[AW-1:0];
            wr_data = rd_q;
        end else begin
            wr_addr = r_pend_addr;
            wr_data = rd_q;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_kept       = r_kept;
        n_idx        = r_idx;
        n_end        = r_end;
        n_first      = r_first;
        n_pend_vld   = 1'b0;
        n_pend_take  = 1'b0;
        n_pend_addr  = r_pend_addr;
        n_out_vld    = r_out_vld;
        n_mode       = r_mode;
        n_value      = r_value;
        n_status     = r_status;
        n_o_status   = r_o_status;
        n_o_rm_value = r_o_rm_value;
        n_o_rm_count = r_o_rm_count;
        n_o_len      = r_o_len;
        new_cnt      = cnt_x;
        rd_en        = 1'b0;
        rd_addr      = r_idx;
        put_en       = 1'b0;
        o_in_ready   = (r_state == S_IDLE);

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        if (filt_wr) begin
            n_kept = r_kept + CW'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode   = i_mode;
                    n_value  = i_value;
                    n_status = ST_OK;
                    n_kept   = '0;
                    n_first  = 1'b1;
                    n_state  = S_DONE;
                    case (i_mode)
                        MODE_INSERT: begin
                            n_end = AW'(pos_x - XW'(1));
                            if (i_position == 8'd0 || pos_x > cnt_x + XW'(1)) begin
                                n_status = ST_BAD_POS;
                            end else if (cnt_x == XW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else if (pos_x == cnt_x + XW'(1)) begin
                                n_state = S_PUT;       // append, nothing to shift
                            end else begin
                                n_idx   = AW'(cnt_x - XW'(1));
                                n_state = S_SCAN;
                            end
                        end
                        MODE_DELETE: begin
                            n_idx = AW'(pos_x - XW'(1));
                            n_end = AW'(cnt_x - XW'(1));
                            if (i_position == 8'd0 || pos_x > cnt_x) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                n_state = S_SCAN;      // first read is the taken word
                            end
                        end
                        MODE_FILTER: begin
                            n_idx = '0;
                            n_end = AW'(cnt_x - XW'(1));
                            if (r_count != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_status = ST_BAD_POS;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                rd_en       = 1'b1;
                n_pend_vld  = 1'b1;
                n_pend_take = r_first && (r_mode == MODE_DELETE);
                n_pend_addr = (r_mode == MODE_INSERT) ? (r_idx + AW'(1))
                                                      : (r_idx - AW'(1));
                n_first     = 1'b0;
                if (r_idx == r_end) begin
                    n_state = S_DRAIN;
                end else if (r_mode == MODE_INSERT) begin
                    n_idx = r_idx - AW'(1);
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_DRAIN: begin
                // last write-back happens this cycle
                n_state = (r_mode == MODE_INSERT) ? S_PUT : S_DONE;
            end
            S_PUT: begin
                put_en  = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_o_status   = r_status;
                    n_o_rm_value = '0;
                    n_o_rm_count = '0;
                    if (r_status == ST_OK) begin
                        case (r_mode)
                            MODE_INSERT: begin
                                new_cnt = cnt_x + XW'(1);
                            end
                            MODE_DELETE: begin
                                new_cnt      = cnt_x - XW'(1);
                                n_o_rm_value = r_taken;
                                n_o_rm_count = 8'd1;
                            end
                            MODE_FILTER: begin
                                if (hits == '0) begin
                                    n_o_status = ST_NOT_FOUND;
                                end else begin
                                    new_cnt      = XW'(r_kept);
                                    n_o_rm_count = 8'(XW'(hits));
                                end
                            end
                            default: begin
                                new_cnt = cnt_x;
                            end
                        endcase
                    end
                    n_count   = CW'(new_cnt);
                    n_o_len   = 8'(new_cnt);
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kept       <= n_kept;
        r_idx        <= n_idx;
        r_end        <= n_end;
        r_first      <= n_first;
        r_pend_take  <= n_pend_take;
        r_pend_addr  <= n_pend_addr;
        r_mode       <= n_mode;
        r_value      <= n_value;
        r_status     <= n_status;
        r_o_status   <= n_o_status;
        r_o_rm_value <= n_o_rm_value;
        r_o_rm_count <= n_o_rm_count;
        r_o_len      <= n_o_len;
        if (take_now) begin
            r_taken <= rd_q;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_status        = r_o_status;
    assign o_removed_value = r_o_rm_value;
    assign o_removed_count = r_o_rm_count;
    assign o_list_length   = r_o_len;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_count) <= XW'(CAPACITY))
        else $error("entry count above capacity");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while previous one still in flight");

    a_no_put_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |-> !r_pend_vld)
        else $error("word write collides with pending write-back");

    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_mode == MODE_FILTER) |-> (r_kept <= r_count))
        else $error("compaction pointer ran past list end");

    a_fail_no_removal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |->
            (o_removed_count == 8'd0 && o_removed_value == 32'sd0))
        else $error("failed request reports a removal");

endmodule
